// ===== rtl/sidec_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
// Used by sidec_front, sidec_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sidec_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  // Wide enough for 9 * 10^9
  localparam int THR_W       = 34;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = 4;

  localparam logic [POS_W-1:0]  TOP_POS    = 4'd9;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  // One classified request: sign flag and unsigned magnitude
  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
  } item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Decimal place weights
  function automatic logic [THR_W-1:0] pow10(input logic [POS_W-1:0] pos);
    logic [THR_W-1:0] w;
    unique case (pos)
      4'd0:    w = 34'd1;
      4'd1:    w = 34'd10;
      4'd2:    w = 34'd100;
      4'd3:    w = 34'd1000;
      4'd4:    w = 34'd10000;
      4'd5:    w = 34'd100000;
      4'd6:    w = 34'd1000000;
      4'd7:    w = 34'd10000000;
      4'd8:    w = 34'd100000000;
      4'd9:    w = 34'd1000000000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sidec_front.sv =====
// Front end: accepts integers, splits them into sign and magnitude and
// holds them in a two-entry queue. Depends on sidec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sidec_front import sidec_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  output queue_head_t                    head,
  input  wire logic                      pop
);

  item_t              store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;
  logic [VALUE_W-1:0] raw;
  item_t              cls;

  // Classify: sign bit and two's complement magnitude
  always_comb begin
    raw          = value;
    cls.negative = raw[VALUE_W-1];
    cls.mag      = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
  end

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = store[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sidec_back.sv =====
// Back end: turns one queued magnitude at a time into sign and decimal
// digits, most significant first, held by out_stall. Depends on sidec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sidec_back import sidec_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire queue_head_t  head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [CHAR_W-1:0] text_char,
  output logic              last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] rem;
  logic [POS_W-1:0]   pos;
  logic               started;

  logic               slot_free;
  logic [THR_W-1:0]   thr [1:9];
  logic [3:0]         digit;
  logic [THR_W-1:0]   sub;
  logic [VALUE_W-1:0] rem_next;
  logic               emit;
  logic [CHAR_W-1:0]  char_next;
  logic               last_next;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == ST_IDLE) && head.valid;

  // Digit select: largest multiple of the place weight that fits
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      thr[d] = pow10(pos) * THR_W'(d);
      if ({2'b00, rem} >= thr[d]) begin
        digit = 4'(d);
        sub   = thr[d];
      end
    end
    rem_next = rem - sub[VALUE_W-1:0];
  end

  // Character to emit this cycle
  always_comb begin
    emit      = 1'b0;
    char_next = CHAR_ZERO;
    last_next = 1'b0;
    unique case (state)
      ST_SIGN: begin
        emit      = 1'b1;
        char_next = CHAR_MINUS;
      end
      ST_DIGIT: begin
        emit      = (digit != 4'd0) || started || (pos == '0);
        char_next = CHAR_ZERO + CHAR_W'(digit);
        last_next = (pos == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            started <= 1'b0;
            state   <= head.item.negative ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (slot_free) begin
            if (digit != 4'd0) begin
              started <= 1'b1;
            end
            if (pos == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working magnitude and digit position
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head.valid) begin
      rem <= head.item.mag;
      pos <= TOP_POS;
    end else if (state == ST_DIGIT && slot_free) begin
      rem <= rem_next;
      if (pos != '0) begin
        pos <= pos - POS_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      text_char <= char_next;
      last      <= last_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Converts each signed 32-bit integer into its decimal ASCII text: an
// optional '-', then the digits most significant first with no leading
// zeros (zero gives "0"); last marks the final digit of each number. A
// front end takes an integer per cycle while in_stall is low into a
// two-entry queue; the back end loads a number in its idle state, emits
// the sign if negative, then steps through the ten decimal places from
// 10^9 down to 10^0, stretched by any out_stall, and loads the next
// number only after the last place. Depends on sidec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_core import sidec_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CHAR_W-1:0]              text_char,
  output logic                           last
);

  queue_head_t head;
  logic        pop;

  // Request intake and classification
  sidec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .head     (head),
    .pop      (pop)
  );

  // Digit generation and output register
  sidec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last      (last)
  );

endmodule

`default_nettype wire
